// ===== design/sk512_pkg.sv =====
// Shared types, constants and helpers for the Skein-512 hash engine.
// No dependencies; used by the controller, datapath and top level.
package sk512_pkg;

	localparam logic [63:0] KS_PARITY = 64'h1BD1_1BDA_A9FC_1A22;
	localparam logic [63:0] CFG_WORD0 = 64'h0000_0001_3341_4853;
	localparam logic [63:0] T0_CFG    = 64'd32;
	localparam logic [63:0] T1_CFG    = 64'hC400_0000_0000_0000;
	localparam logic [63:0] T0_OUT    = 64'd8;
	localparam logic [63:0] T1_OUT    = 64'hFF00_0000_0000_0000;
	localparam logic [7:0]  FLAG_MSG   = 8'h30;
	localparam logic [7:0]  FLAG_FIRST = 8'h40;
	localparam logic [7:0]  FLAG_FINAL = 8'h80;
	localparam logic [6:0]  BLOCK_BYTES = 7'd64;
	localparam logic [0:0]  REG_ROUNDS = 1'b0;
	localparam logic [0:0]  REG_DLEN   = 1'b1;

	localparam logic [5:0] ROT [8][4] = '{
		'{6'd46, 6'd36, 6'd19, 6'd37}, '{6'd33, 6'd27, 6'd14, 6'd42},
		'{6'd17, 6'd49, 6'd36, 6'd39}, '{6'd44, 6'd9,  6'd54, 6'd56},
		'{6'd39, 6'd30, 6'd34, 6'd24}, '{6'd13, 6'd50, 6'd10, 6'd17},
		'{6'd25, 6'd29, 6'd39, 6'd43}, '{6'd8,  6'd35, 6'd56, 6'd22}};

	typedef enum logic [4:0] {
		ST_CFG_LD, ST_CFG_RUN, ST_CFG_WR, ST_IDLE,
		ST_ABS_POS, ST_ABS_LD, ST_ABS_RUN, ST_ABS_WR,
		ST_FIN_POS, ST_FIN_LD, ST_FIN_RUN, ST_FIN_WR,
		ST_OUT_LD, ST_OUT_RUN, ST_OUT_WR, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {SRC_CFG, SRC_MSG, SRC_OUT} src_t;

	typedef struct packed {
		logic load;
		src_t src;
		logic fin;
		logic step;
		logic wr_chain;
		logic wr_cfg;
		logic pos_full;
		logic pos_cnt;
		logic clr;
		logic reload;
		logic latch;
		logic store_in;
		logic store_pend;
		logic emit_adv;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic full;
		logic last;
		logic empty;
	} stat_t;

	function automatic logic [63:0] rotl64(logic [63:0] x, logic [5:0] r);
		return (x << r) | (x >> (7'd64 - {1'b0, r}));
	endfunction

endpackage

// ===== design/sk512_ctrl.sv =====
// Controller state machine for the Skein-512 hash engine.
// Depends on sk512_pkg; drives sk512_dp through cmd_t, reads stat_t.
module sk512_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tuser,
	input  logic            m_tready,
	input  logic            cfg_we,
	input  sk512_pkg::stat_t stat,
	output sk512_pkg::cmd_t  cmd,
	output logic            s_tready,
	output logic            m_tvalid
);
	import sk512_pkg::*;

	state_t state_q, state_d;
	logic   acc;

	assign acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CFG_LD;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CFG_LD:  state_d = ST_CFG_RUN;
			ST_CFG_RUN: if (stat.done) state_d = ST_CFG_WR;
			ST_CFG_WR:  state_d = ST_IDLE;
			ST_IDLE: begin
				if (cfg_we) state_d = ST_CFG_LD;
				else if (acc && s_tuser) state_d = ST_FIN_POS;
				else if (acc && stat.full) state_d = ST_ABS_POS;
			end
			ST_ABS_POS: state_d = ST_ABS_LD;
			ST_ABS_LD:  state_d = ST_ABS_RUN;
			ST_ABS_RUN: if (stat.done) state_d = ST_ABS_WR;
			ST_ABS_WR:  state_d = ST_IDLE;
			ST_FIN_POS: state_d = ST_FIN_LD;
			ST_FIN_LD:  state_d = ST_FIN_RUN;
			ST_FIN_RUN: if (stat.done) state_d = ST_FIN_WR;
			ST_FIN_WR:  state_d = ST_OUT_LD;
			ST_OUT_LD:  state_d = ST_OUT_RUN;
			ST_OUT_RUN: if (stat.done) state_d = ST_OUT_WR;
			ST_OUT_WR:  state_d = stat.empty ? ST_IDLE : ST_EMIT;
			ST_EMIT:    if (m_tready && stat.last) state_d = ST_IDLE;
			default:    state_d = ST_CFG_LD;
		endcase
		if (cfg_we) state_d = ST_CFG_LD;
	end

	always_comb begin
		cmd      = '0;
		cmd.src  = SRC_MSG;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_CFG_LD: begin
				cmd.load = 1'b1;
				cmd.src  = SRC_CFG;
			end
			ST_CFG_WR: begin
				cmd.wr_chain = 1'b1;
				cmd.wr_cfg   = 1'b1;
				cmd.clr      = 1'b1;
			end
			ST_IDLE: begin
				s_tready       = !cfg_we;
				cmd.latch      = acc;
				cmd.store_in   = acc && !s_tuser && !stat.full;
			end
			ST_ABS_POS: cmd.pos_full = 1'b1;
			ST_ABS_LD:  cmd.load = 1'b1;
			ST_ABS_WR: begin
				cmd.wr_chain   = 1'b1;
				cmd.store_pend = 1'b1;
			end
			ST_FIN_POS: cmd.pos_cnt = 1'b1;
			ST_FIN_LD: begin
				cmd.load = 1'b1;
				cmd.fin  = 1'b1;
			end
			ST_FIN_WR:  cmd.wr_chain = 1'b1;
			ST_OUT_LD: begin
				cmd.load = 1'b1;
				cmd.src  = SRC_OUT;
			end
			ST_OUT_WR: begin
				cmd.wr_chain = 1'b1;
				cmd.reload   = stat.empty;
				cmd.clr      = stat.empty;
			end
			ST_EMIT: begin
				m_tvalid     = 1'b1;
				cmd.emit_adv = m_tready;
				cmd.reload   = m_tready && stat.last;
				cmd.clr      = m_tready && stat.last;
			end
			ST_CFG_RUN, ST_ABS_RUN, ST_FIN_RUN, ST_OUT_RUN: cmd.step = !stat.done;
			default: ;
		endcase
	end

endmodule

// ===== design/sk512_dp.sv =====
// Datapath: config registers, message buffer, chain and Threefish-512 round unit.
// Depends on sk512_pkg; sequenced by sk512_ctrl.
module sk512_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  sk512_pkg::cmd_t  cmd,
	output sk512_pkg::stat_t stat,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic [7:0]       in_byte,
	output logic [7:0]       digest_byte,
	output logic             digest_last
);
	import sk512_pkg::*;

	logic [7:0]   rounds_q;
	logic [6:0]   dlen_q;
	logic [63:0]  chain_q [8];
	logic [63:0]  cfgc_q [8];
	logic [511:0] buf_q;
	logic [6:0]   count_q;
	logic [95:0]  pos_q;
	logic         first_q;
	logic [7:0]   byte_q;
	logic [63:0]  v_q [8];
	logic [63:0]  k_q [9];
	logic [63:0]  t_q [3];
	logic [63:0]  m_q [8];
	logic [7:0]   d_q;
	logic         inj_q;
	logic [5:0]   s_q;
	logic [5:0]   idx_q;

	logic [6:0]   eff_len;
	logic [7:0]   nr;
	logic [63:0]  ld_m [8];
	logic [63:0]  ld_k [8];
	logic [63:0]  ld_t0, ld_t1;
	logic [63:0]  ld_k8;
	logic [7:0]   flags;
	logic [63:0]  mix [8];
	logic [63:0]  inj [8];
	logic [511:0] chain_flat;

	assign eff_len = (dlen_q > BLOCK_BYTES) ? BLOCK_BYTES : dlen_q;
	assign nr      = {rounds_q[7:3], 3'b000};

	always_comb begin
		flags = FLAG_MSG | (first_q ? FLAG_FIRST : 8'h00) | (cmd.fin ? FLAG_FINAL : 8'h00);
		ld_k8 = KS_PARITY;
		for (int i = 0; i < 8; i++) begin
			ld_m[i] = '0;
			ld_k[i] = chain_q[i];
			for (int j = 0; j < 8; j++) begin
				if (7'(8 * i + j) < count_q) ld_m[i][8*j +: 8] = buf_q[64*i + 8*j +: 8];
			end
		end
		ld_t0 = pos_q[63:0];
		ld_t1 = {flags, 24'd0, pos_q[95:64]};
		case (cmd.src)
			SRC_CFG: begin
				for (int i = 0; i < 8; i++) begin
					ld_m[i] = '0;
					ld_k[i] = '0;
				end
				ld_m[0] = CFG_WORD0;
				ld_m[1] = {54'd0, eff_len, 3'b000};
				ld_t0   = T0_CFG;
				ld_t1   = T1_CFG;
			end
			SRC_OUT: begin
				for (int i = 0; i < 8; i++) ld_m[i] = '0;
				ld_t0 = T0_OUT;
				ld_t1 = T1_OUT;
			end
			default: ;
		endcase
		for (int i = 0; i < 8; i++) ld_k8 = ld_k8 ^ ld_k[i];
	end

	always_comb begin
		logic [63:0] tmp [8];
		for (int i = 0; i < 4; i++) begin
			tmp[2*i]   = v_q[2*i] + v_q[2*i+1];
			tmp[2*i+1] = rotl64(v_q[2*i+1], ROT[d_q[2:0]][i]) ^ tmp[2*i];
		end
		mix[0] = tmp[2]; mix[1] = tmp[1]; mix[2] = tmp[4]; mix[3] = tmp[7];
		mix[4] = tmp[6]; mix[5] = tmp[5]; mix[6] = tmp[0]; mix[7] = tmp[3];
		for (int i = 0; i < 5; i++) inj[i] = v_q[i] + k_q[i];
		inj[5] = v_q[5] + k_q[5] + t_q[0];
		inj[6] = v_q[6] + k_q[6] + t_q[1];
		inj[7] = v_q[7] + k_q[7] + {58'd0, s_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q   <= '0;
			inj_q <= 1'b0;
			s_q   <= '0;
		end else if (cmd.load) begin
			d_q   <= '0;
			inj_q <= 1'b1;
			s_q   <= '0;
		end else if (cmd.step) begin
			if (inj_q) begin
				inj_q <= 1'b0;
				s_q   <= s_q + 6'd1;
			end else begin
				d_q   <= d_q + 8'd1;
				inj_q <= (d_q[1:0] == 2'd3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= ld_m[i];
				m_q[i] <= ld_m[i];
				k_q[i] <= ld_k[i];
			end
			k_q[8] <= ld_k8;
			t_q[0] <= ld_t0;
			t_q[1] <= ld_t1;
			t_q[2] <= ld_t0 ^ ld_t1;
		end else if (cmd.step) begin
			if (inj_q) begin
				for (int i = 0; i < 8; i++) v_q[i] <= inj[i];
				for (int i = 0; i < 8; i++) k_q[i] <= k_q[i+1];
				k_q[8] <= k_q[0];
				t_q[0] <= t_q[1];
				t_q[1] <= t_q[2];
				t_q[2] <= t_q[0];
			end else begin
				for (int i = 0; i < 8; i++) v_q[i] <= mix[i];
			end
		end
	end

	assign stat.done = !inj_q && (d_q == nr);

	always_ff @(posedge clk) begin
		if (cmd.wr_cfg) begin
			for (int i = 0; i < 8; i++) cfgc_q[i] <= v_q[i] ^ m_q[i];
		end
		if (cmd.reload) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= cfgc_q[i];
		end else if (cmd.wr_chain) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= v_q[i] ^ m_q[i];
		end
		if (cmd.latch) byte_q <= in_byte;
		if (cmd.store_in) buf_q[{count_q[5:0], 3'b000} +: 8] <= in_byte;
		else if (cmd.store_pend) buf_q[7:0] <= byte_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q <= 8'd72;
			dlen_q   <= 7'd64;
			count_q  <= '0;
			pos_q    <= '0;
			first_q  <= 1'b1;
			idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROUNDS: rounds_q <= cfg_data;
					REG_DLEN:   dlen_q   <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (cmd.clr) begin
				count_q <= '0;
				pos_q   <= '0;
				first_q <= 1'b1;
				idx_q   <= '0;
			end else begin
				if (cmd.store_in) count_q <= count_q + 7'd1;
				if (cmd.store_pend) begin
					count_q <= 7'd1;
					first_q <= 1'b0;
				end
				if (cmd.pos_full) pos_q <= pos_q + 96'(BLOCK_BYTES);
				if (cmd.pos_cnt)  pos_q <= pos_q + 96'(count_q);
				if (cmd.emit_adv) idx_q <= idx_q + 6'd1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) chain_flat[64*i +: 64] = chain_q[i];
	end

	assign digest_byte = chain_flat[{idx_q, 3'b000} +: 8];
	assign digest_last = ({1'b0, idx_q} == eff_len - 7'd1);
	assign stat.last   = digest_last;
	assign stat.full   = (count_q == BLOCK_BYTES);
	assign stat.empty  = (eff_len == 7'd0);

endmodule

// ===== design/skein512_hash_engine.sv =====
// Top level of the Skein-512 hash engine: joins controller and datapath.
// Depends on sk512_pkg, sk512_ctrl and sk512_dp.
//
// Skein-512 (Threefish-512 in UBI chaining): one message byte per absorb
// transaction, a finish transaction (tuser high) emits min(digest_len, 64)
// bytes with tlast on the final one. One round unit does one Threefish round or
// one subkey injection per cycle. An absorb that arrives while a full 64-byte
// block is buffered first compresses that block; a finish compresses the final
// message block and then the output block before it emits the digest bytes,
// held while the output is stalled. After reset or any register write the
// configuration block is compressed first before input is taken again.
module skein512_hash_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] msg_byte
	input  logic       s_tuser,   // [0] req_type
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] digest_byte
	output logic       m_tlast,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import sk512_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	sk512_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.stat     (stat),
		.cmd      (cmd),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid)
	);

	sk512_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_byte     (s_tdata),
		.digest_byte (m_tdata),
		.digest_last (m_tlast)
	);

endmodule

// ===== design/sk512_checker.sv =====
// Port-level checker for skein512_hash_engine, attached by bind.
// No package dependency.
module sk512_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while digest pending");

	a_absorb_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !m_tvalid)
		else $error("digest after absorb");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("digest continues after last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled digest byte changed");
endmodule

bind skein512_hash_engine sk512_checker u_sk512_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the Skein-512 hash engine: streams message bytes and
// finish requests, predicts every digest byte with its own Threefish/UBI model.
// Depends on sk512_pkg and skein512_hash_engine.
module tb_top;
	import sk512_pkg::*;

	typedef struct packed {
		logic       fin;
		logic [7:0] data;
	} req_t;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       last;
	} dig_t;

	localparam int WATCHDOG = 200000;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;

	req_t pending_reqs[$];
	dig_t digest_fifo[$];

	logic [7:0]  mdl_rounds;
	logic [6:0]  mdl_dlen;
	logic [63:0] mdl_chain[8];
	logic [63:0] mdl_cfg_chain[8];
	logic [7:0]  mdl_buf[64];
	int          mdl_count;
	logic [95:0] mdl_pos;
	logic        mdl_first;

	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_recv;
	int  hold_cycles;
	int  errors;
	int  quiet_cycles;
	bit  stim_done;

	skein512_hash_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic logic [63:0] rot_left(logic [63:0] x, int r);
		if (r == 0)
			return x;
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic int rot_amt(int d, int i);
		int tab[32] = '{46, 36, 19, 37, 33, 27, 14, 42, 17, 49, 36, 39, 44, 9, 54, 56,
			39, 30, 34, 24, 13, 50, 10, 17, 25, 29, 39, 43, 8, 35, 56, 22};
		return tab[d * 4 + i];
	endfunction

	task automatic ubi_compress(inout logic [63:0] h[8], input logic [7:0] blk[64],
			input logic [63:0] t0, input logic [63:0] t1);
		logic [63:0] k[9];
		logic [63:0] tw[3];
		logic [63:0] m[8];
		logic [63:0] v[8];
		logic [63:0] tmp[8];
		int perm[8] = '{2, 1, 4, 7, 6, 5, 0, 3};
		int nr;
		int s;
		nr = (mdl_rounds >> 3) * 8;
		k[8] = 64'h1BD1_1BDA_A9FC_1A22;
		for (int i = 0; i < 8; i++) begin
			k[i] = h[i];
			k[8] ^= h[i];
			for (int b = 0; b < 8; b++)
				m[i][8*b +: 8] = blk[8*i + b];
			v[i] = m[i];
		end
		tw[0] = t0;
		tw[1] = t1;
		tw[2] = t0 ^ t1;
		for (int d = 0; d <= nr; d++) begin
			if (d % 4 == 0) begin
				s = d / 4;
				for (int i = 0; i < 8; i++)
					v[i] += k[(s + i) % 9];
				v[5] += tw[s % 3];
				v[6] += tw[(s + 1) % 3];
				v[7] += 64'(s);
			end
			if (d == nr)
				break;
			for (int i = 0; i < 4; i++) begin
				v[2*i] += v[2*i+1];
				v[2*i+1] = rot_left(v[2*i+1], rot_amt(d % 8, i)) ^ v[2*i];
			end
			for (int i = 0; i < 8; i++)
				tmp[i] = v[perm[i]];
			v = tmp;
		end
		for (int i = 0; i < 8; i++)
			h[i] = v[i] ^ m[i];
	endtask

	function automatic int digest_bytes();
		return (mdl_dlen > 64) ? 64 : int'(mdl_dlen);
	endfunction

	task automatic restart_hash();
		mdl_chain = mdl_cfg_chain;
		mdl_count = 0;
		mdl_pos = '0;
		mdl_first = 1'b1;
	endtask

	task automatic rebuild_config();
		logic [7:0]  cfg_blk[64];
		logic [63:0] bits;
		bits = 64'(digest_bytes() * 8);
		foreach (cfg_blk[i])
			cfg_blk[i] = 8'h00;
		cfg_blk[0] = "S";
		cfg_blk[1] = "H";
		cfg_blk[2] = "A";
		cfg_blk[3] = "3";
		cfg_blk[4] = 8'd1;
		for (int i = 0; i < 8; i++)
			cfg_blk[8 + i] = bits[8*i +: 8];
		foreach (mdl_cfg_chain[i])
			mdl_cfg_chain[i] = '0;
		ubi_compress(mdl_cfg_chain, cfg_blk, T0_CFG, T1_CFG);
		restart_hash();
	endtask

	function automatic logic [63:0] msg_tweak_hi(bit fin);
		logic [7:0] flags;
		flags = FLAG_MSG;
		if (mdl_first)
			flags |= FLAG_FIRST;
		if (fin)
			flags |= FLAG_FINAL;
		return {flags, 24'h0, mdl_pos[95:64]};
	endfunction

	task automatic predict_digest(req_t r);
		logic [7:0] zero_blk[64];
		int n;
		dig_t d;
		if (!r.fin) begin
			if (mdl_count >= 64) begin
				mdl_pos += 96'd64;
				ubi_compress(mdl_chain, mdl_buf, mdl_pos[63:0], msg_tweak_hi(0));
				mdl_first = 1'b0;
				mdl_count = 0;
			end
			mdl_buf[mdl_count] = r.data;
			mdl_count++;
			return;
		end
		mdl_pos += 96'(mdl_count);
		for (int i = mdl_count; i < 64; i++)
			mdl_buf[i] = 8'h00;
		ubi_compress(mdl_chain, mdl_buf, mdl_pos[63:0], msg_tweak_hi(1));
		foreach (zero_blk[i])
			zero_blk[i] = 8'h00;
		ubi_compress(mdl_chain, zero_blk, T0_OUT, T1_OUT);
		n = digest_bytes();
		for (int i = 0; i < n; i++) begin
			d.byte_val = mdl_chain[i / 8][8*(i % 8) +: 8];
			d.last = (i + 1 == n);
			digest_fifo.push_back(d);
		end
		restart_hash();
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if ((!s_tvalid || s_tready) && pending_reqs.size() > (s_tvalid && s_tready)) begin
				if ($urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser  <= pending_reqs[s_tvalid && s_tready].fin;
					s_tdata  <= pending_reqs[s_tvalid && s_tready].data;
				end else begin
					s_tvalid <= 1'b0;
				end
			end else if (s_tvalid && s_tready) begin
				s_tvalid <= 1'b0;
			end
			if (s_tvalid && s_tready) begin
				predict_digest(req_t'{s_tuser, s_tdata});
				void'(pending_reqs.pop_front());
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (digest_fifo.size() == 0) begin
					$error("unexpected digest byte %02h", m_tdata);
					errors++;
				end else begin
					if (m_tdata !== digest_fifo[0].byte_val) begin
						$error("digest_byte expected %02h actual %02h",
							digest_fifo[0].byte_val, m_tdata);
						errors++;
					end
					if (m_tlast !== digest_fifo[0].last) begin
						$error("digest_last expected %0b actual %0b",
							digest_fifo[0].last, m_tlast);
						errors++;
					end
					void'(digest_fifo.pop_front());
				end
			end
			if (hold_recv)
				m_tready <= 1'b0;
			else
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_recv <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			hold_recv <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || stim_done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic add_req(bit fin, logic [7:0] data);
		pending_reqs.push_back(req_t'{fin, data});
	endtask

	task automatic add_message(int len);
		for (int i = 0; i < len; i++)
			add_req(1'b0, 8'($urandom));
		add_req(1'b1, 8'($urandom));
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || s_tvalid)
			@(posedge clk);
		while (digest_fifo.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_ROUNDS)
			mdl_rounds = val;
		else
			mdl_dlen = val[6:0];
		rebuild_config();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int msgs, int idle, int stall);
		int len;
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < msgs; i++) begin
			case ($urandom_range(5))
				0: len = 0;
				1: len = 64;
				2: len = 64 + $urandom_range(1, 8);
				default: len = $urandom_range(1, 20);
			endcase
			add_message(len);
		end
		drain();
	endtask

	initial begin
		errors = 0;
		quiet_cycles = 0;
		stim_done = 0;
		hold_recv = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mdl_rounds = 8'd72;
		mdl_dlen = 7'd64;
		rebuild_config();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, extreme bytes, exact block, block plus one
		add_req(1'b1, 8'h00);
		add_req(1'b0, 8'h00);
		add_req(1'b0, 8'hFF);
		add_req(1'b0, 8'hA5);
		add_req(1'b1, 8'hFF);
		drain();
		add_message(64);
		add_message(65);
		drain();

		write_reg(REG_ROUNDS, 8'd8);
		write_reg(REG_DLEN, 8'd1);
		add_message(3);
		add_message(0);
		drain();
		write_reg(REG_ROUNDS, 8'd13);
		write_reg(REG_DLEN, 8'd0);
		add_message(2);
		drain();
		write_reg(REG_ROUNDS, 8'd4);
		write_reg(REG_DLEN, 8'd127);
		add_message(5);
		drain();
		write_reg(REG_ROUNDS, 8'd248);
		write_reg(REG_DLEN, 8'd64);
		add_message(1);
		drain();
		write_reg(REG_ROUNDS, 8'd255);
		write_reg(REG_DLEN, 8'd65);
		add_message(2);
		drain();

		// backpressure: receiver holds off while sender keeps going
		write_reg(REG_ROUNDS, 8'd16);
		write_reg(REG_DLEN, 8'd32);
		hold_cycles = 3000;
		add_message(4);
		add_message(4);
		add_message(4);
		drain();

		write_reg(REG_ROUNDS, 8'd72);
		write_reg(REG_DLEN, 8'($urandom_range(1, 64)));
		random_phase(1, 0, 0);
		write_reg(REG_ROUNDS, 8'($urandom_range(8, 40)));
		write_reg(REG_DLEN, 8'($urandom_range(1, 64)));
		random_phase(1, 48, 0);
		write_reg(REG_ROUNDS, 8'($urandom));
		write_reg(REG_DLEN, 8'($urandom));
		random_phase(1, 0, 48);
		write_reg(REG_ROUNDS, 8'd72);
		write_reg(REG_DLEN, 8'($urandom_range(1, 64)));
		random_phase(1, 22, 22);

		stim_done = 1;
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
